// File: src/mfb_pkg.sv
package mfb_pkg;

   // Screen geometry and scanout timing.
   localparam int SCREEN_WIDTH  = 160;
   localparam int SCREEN_HEIGHT = 120;
   localparam int ROW_REPEAT    = 3;
   localparam int TOP_BLANK     = 96;
   localparam int LINE_BYTES    = 21;

   localparam int ROW_BYTES    = (SCREEN_WIDTH + 7) / 8;
   localparam int STORE_BYTES  = ROW_BYTES * SCREEN_HEIGHT;
   localparam int IMAGE_END    = TOP_BLANK + SCREEN_HEIGHT * ROW_REPEAT;
   localparam int COUNT_MAX    = 1023;

   localparam int ADDR_W  = $clog2(STORE_BYTES);
   localparam int ROW_W   = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;
   localparam int BYTE_W  = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
   localparam int K_W     = $clog2(LINE_BYTES);
   localparam int REP_W   = $clog2(ROW_REPEAT + 1);
   localparam int COORD_W = 10;
   localparam int CNT_W   = 10;

   // Command codes carried in the input tuser.
   typedef enum logic [2:0] {
      ACT_PIXEL  = 3'd0,
      ACT_FILL   = 3'd1,
      ACT_RECT   = 3'd2,
      ACT_CLEAR  = 3'd3,
      ACT_COLORS = 3'd4,
      ACT_TICK   = 3'd5,
      ACT_FRAME  = 3'd6,
      ACT_NONE   = 3'd7
   } action_type;

   // Result status codes.
   localparam logic [1:0] STS_OK        = 2'd0;
   localparam logic [1:0] STS_FIRST_BAD = 2'd1;
   localparam logic [1:0] STS_LAST_BAD  = 2'd2;
   localparam logic [1:0] STS_COLOR_BAD = 2'd3;

   // Controller to datapath commands.
   typedef struct packed {
      logic load;
      logic fill_step;
      logic rect_rd;
      logic rect_wr;
      logic color_step;
      logic scan_rd;
      logic scan_next;
      logic scan_show;
   } cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic fill_end;
      logic rect_empty;
      logic rect_done;
      logic color_bad;
      logic color_end;
      logic scan_end;
   } sts_type;

endpackage

// File: src/mfb_ctrl.sv
module mfb_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [2:0]       req_action,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output mfb_pkg::cmd_type cmd,
   input  mfb_pkg::sts_type sts
);
   import mfb_pkg::*;

   typedef enum logic [8:0] {
      S_CLEAR    = 9'b000000001,
      S_IDLE     = 9'b000000010,
      S_RECT_RD  = 9'b000000100,
      S_RECT_WR  = 9'b000001000,
      S_FILL     = 9'b000010000,
      S_COLOR    = 9'b000100000,
      S_SCAN_RD  = 9'b001000000,
      S_SCAN_OUT = 9'b010000000,
      S_RESP     = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   action_type act;

   assign act = action_type'(req_action);

   // Next state and command decode.
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.fill_step = 1'b1;
            if (sts.fill_end) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               unique case (act)
                  ACT_PIXEL, ACT_RECT, ACT_CLEAR: state_in = S_RECT_RD;
                  ACT_FILL:                       state_in = S_FILL;
                  ACT_COLORS:                     state_in = S_COLOR;
                  ACT_TICK:                       state_in = S_SCAN_RD;
                  default:                        state_in = S_RESP;
               endcase
            end
         end
         S_RECT_RD: begin
            if (sts.rect_empty) begin
               state_in = S_RESP;
            end else begin
               cmd.rect_rd = 1'b1;
               state_in    = S_RECT_WR;
            end
         end
         S_RECT_WR: begin
            cmd.rect_wr = 1'b1;
            state_in    = sts.rect_done ? S_RESP : S_RECT_RD;
         end
         S_FILL: begin
            cmd.fill_step = 1'b1;
            if (sts.fill_end) state_in = S_RESP;
         end
         S_COLOR: begin
            if (sts.color_bad) begin
               state_in = S_RESP;
            end else begin
               cmd.color_step = 1'b1;
               if (sts.color_end) state_in = S_RESP;
            end
         end
         S_SCAN_RD: begin
            cmd.scan_rd = 1'b1;
            state_in    = S_SCAN_OUT;
         end
         S_SCAN_OUT: begin
            cmd.scan_show = 1'b1;
            rsp_tvalid    = 1'b1;
            if (rsp_tready) begin
               cmd.scan_next = 1'b1;
               state_in      = sts.scan_end ? S_IDLE : S_SCAN_RD;
            end
         end
         S_RESP: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_CLEAR;
      else       state_ff <= state_in;
   end

endmodule

// File: src/mfb_data.sv
module mfb_data (
   input  logic             clock,
   input  logic             reset,
   input  mfb_pkg::cmd_type cmd,
   output mfb_pkg::sts_type sts,
   input  logic [2:0]       req_action,
   input  logic [7:0]       x_first,
   input  logic [7:0]       y_first,
   input  logic [7:0]       x_second,
   input  logic [7:0]       y_second,
   input  logic [7:0]       value,
   output logic [1:0]       status,
   output logic [7:0]       pixel_byte,
   output logic [2:0]       line_color,
   output logic             image_line,
   output logic             last
);
   import mfb_pkg::*;

   // Pixel and colour memories with their registered read data.
   logic [7:0]         pix_mem [STORE_BYTES];
   logic [2:0]         col_mem [SCREEN_HEIGHT];
   logic [SCREEN_HEIGHT-1:0] col_valid_ff;
   logic [7:0]         pix_rd_ff;
   logic [2:0]         col_rd_ff;
   logic               col_rd_valid_ff;

   // Command operands.
   logic [COORD_W-1:0] x_lo_ff, x_hi_ff, y_lo_ff, y_hi_ff, y_cur_ff;
   logic [BYTE_W-1:0]  byte_cur_ff;
   logic               on_ff;
   logic [1:0]         status_ff;
   logic [7:0]         fill_byte_ff;
   logic [ADDR_W-1:0]  fill_addr_ff;
   logic [ROW_W-1:0]   line_ff, line_end_ff;
   logic [2:0]         code_ff;

   // Scanout state.
   logic [CNT_W-1:0]   count_ff;
   logic [REP_W-1:0]   repeat_ff;
   logic [ROW_W-1:0]   shown_ff, row_ff;
   logic               image_ff;
   logic [K_W-1:0]     k_ff;

   action_type         act;
   logic [COORD_W-1:0] x0, x1c, y0, y1c, yf, yl;
   logic [BYTE_W-1:0]  byte_lo, byte_hi;
   logic [2:0]         bit_lo, bit_hi;
   logic [7:0]         mask;
   logic [ADDR_W-1:0]  rect_addr, scan_addr;
   logic               k_in_row;

   assign act = action_type'(req_action);
   assign x0  = COORD_W'(x_first);
   assign y0  = COORD_W'(y_first);
   assign x1c = (COORD_W'(x_second) > COORD_W'(SCREEN_WIDTH - 1)) ?
                COORD_W'(SCREEN_WIDTH - 1) : COORD_W'(x_second);
   assign y1c = (COORD_W'(y_second) > COORD_W'(SCREEN_HEIGHT - 1)) ?
                COORD_W'(SCREEN_HEIGHT - 1) : COORD_W'(y_second);
   assign yf  = COORD_W'(y_first);
   assign yl  = COORD_W'(y_second);

   // Byte span and bit mask of the current rectangle byte, MSB leftmost.
   assign byte_lo   = BYTE_W'(x_lo_ff >> 3);
   assign byte_hi   = BYTE_W'(x_hi_ff >> 3);
   assign bit_lo    = (byte_cur_ff == byte_lo) ? x_lo_ff[2:0] : 3'd0;
   assign bit_hi    = (byte_cur_ff == byte_hi) ? x_hi_ff[2:0] : 3'd7;
   assign mask      = (8'hFF >> bit_lo) & (8'hFF << (3'd7 - bit_hi));
   assign rect_addr = ADDR_W'(ADDR_W'(y_cur_ff) * ADDR_W'(ROW_BYTES)) + ADDR_W'(byte_cur_ff);
   assign k_in_row  = (int'(k_ff) < ROW_BYTES) && (int'(k_ff) < LINE_BYTES - 1);
   assign scan_addr = ADDR_W'(ADDR_W'(row_ff) * ADDR_W'(ROW_BYTES)) +
                      (k_in_row ? ADDR_W'(k_ff) : ADDR_W'(0));

   assign sts.fill_end   = (int'(fill_addr_ff) == STORE_BYTES - 1);
   assign sts.rect_empty = (x_lo_ff > x_hi_ff) || (y_lo_ff > y_hi_ff);
   assign sts.rect_done  = (byte_cur_ff == byte_hi) && (y_cur_ff == y_hi_ff);
   assign sts.color_bad  = (status_ff != STS_OK);
   assign sts.color_end  = (line_ff == line_end_ff);
   assign sts.scan_end   = (int'(k_ff) == LINE_BYTES - 1);

   // Result fields: scanout beat or single command answer.
   always_comb begin
      if (cmd.scan_show) begin
         status     = STS_OK;
         pixel_byte = (image_ff && k_in_row) ? pix_rd_ff : 8'h00;
         line_color = image_ff ? (col_rd_valid_ff ? col_rd_ff : 3'd7) : 3'd0;
         image_line = image_ff;
         last       = sts.scan_end;
      end else begin
         status     = status_ff;
         pixel_byte = 8'h00;
         line_color = 3'd0;
         image_line = 1'b0;
         last       = 1'b1;
      end
   end

   // Pixel memory: fill sweep, read-modify-write and scanout read.
   always_ff @(posedge clock) begin
      if (cmd.fill_step) pix_mem[fill_addr_ff] <= fill_byte_ff;
      if (cmd.rect_wr) begin
         pix_mem[rect_addr] <= on_ff ? (pix_rd_ff | mask) : (pix_rd_ff & ~mask);
      end
      if (cmd.rect_rd)      pix_rd_ff <= pix_mem[rect_addr];
      else if (cmd.scan_rd) pix_rd_ff <= pix_mem[scan_addr];
   end

   // Colour memory; an entry never written reads as white.
   always_ff @(posedge clock) begin
      if (cmd.color_step) col_mem[line_ff] <= code_ff;
      if (cmd.scan_rd) begin
         col_rd_ff       <= col_mem[row_ff];
         col_rd_valid_ff <= col_valid_ff[row_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_valid_ff <= '0;
      end else if (cmd.color_step) begin
         col_valid_ff[line_ff] <= 1'b1;
      end
   end

   // Operand capture and sweep counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_addr_ff <= '0;
         fill_byte_ff <= 8'h00;
         status_ff    <= STS_OK;
      end else if (cmd.load) begin
         fill_addr_ff <= '0;
         fill_byte_ff <= (value != 8'h00) ? 8'hFF : 8'h00;
         status_ff    <= STS_OK;
         if (act == ACT_COLORS) begin
            priority if (int'(y_first) >= SCREEN_HEIGHT)  status_ff <= STS_FIRST_BAD;
            else if (int'(y_second) >= SCREEN_HEIGHT)     status_ff <= STS_LAST_BAD;
            else if (value > 8'd7)                        status_ff <= STS_COLOR_BAD;
         end
      end else if (cmd.fill_step) begin
         fill_addr_ff <= fill_addr_ff + ADDR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         code_ff <= value[2:0];
         if (yf > yl) begin
            line_ff     <= ROW_W'(yl);
            line_end_ff <= ROW_W'(yf);
         end else begin
            line_ff     <= ROW_W'(yf);
            line_end_ff <= ROW_W'(yl);
         end
         x_lo_ff     <= x0;
         y_lo_ff     <= y0;
         y_cur_ff    <= y0;
         byte_cur_ff <= BYTE_W'(x0 >> 3);
         if (act == ACT_PIXEL) begin
            x_hi_ff <= (x0 > COORD_W'(SCREEN_WIDTH - 1)) ? COORD_W'(0) : x0;
            y_hi_ff <= (y0 > COORD_W'(SCREEN_HEIGHT - 1)) ? COORD_W'(0) : y0;
            on_ff   <= (value != 8'h00);
         end else begin
            x_hi_ff <= x1c;
            y_hi_ff <= y1c;
            on_ff   <= (act == ACT_RECT);
         end
      end else if (cmd.color_step) begin
         line_ff <= line_ff + ROW_W'(1);
      end else if (cmd.rect_wr) begin
         if (byte_cur_ff == byte_hi) begin
            byte_cur_ff <= byte_lo;
            y_cur_ff    <= y_cur_ff + COORD_W'(1);
         end else begin
            byte_cur_ff <= byte_cur_ff + BYTE_W'(1);
         end
      end
   end

   // Line counter, repeat count and shown row, advanced at each line tick.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         repeat_ff <= REP_W'(ROW_REPEAT);
         shown_ff  <= '0;
         image_ff  <= 1'b0;
         row_ff    <= '0;
         k_ff      <= '0;
      end else if (cmd.load && act == ACT_FRAME) begin
         count_ff <= '0;
      end else if (cmd.load && act == ACT_TICK) begin
         k_ff     <= '0;
         row_ff   <= shown_ff;
         image_ff <= 1'b0;
         priority if (int'(count_ff) < TOP_BLANK) begin
            repeat_ff <= REP_W'(ROW_REPEAT);
            shown_ff  <= '0;
         end else if (int'(count_ff) < IMAGE_END) begin
            image_ff <= 1'b1;
            if (repeat_ff <= REP_W'(1)) begin
               repeat_ff <= REP_W'(ROW_REPEAT);
               shown_ff  <= (int'(shown_ff) + 1 >= SCREEN_HEIGHT) ? ROW_W'(0) :
                            shown_ff + ROW_W'(1);
            end else begin
               repeat_ff <= repeat_ff - REP_W'(1);
            end
         end else begin
            shown_ff <= '0;
         end
         if (int'(count_ff) < COUNT_MAX) count_ff <= count_ff + CNT_W'(1);
      end else if (cmd.scan_next) begin
         k_ff <= k_ff + K_W'(1);
      end
   end

endmodule

// File: src/mono_framebuffer_draw_and_scanout.sv
// Channel   Direction  Handshake              Payload
// req_      in         req_tvalid/req_tready  tuser action, tdata coordinates and value
// rsp_      out        rsp_tvalid/rsp_tready  tdata status and scanout byte, tlast
//
// One item at a time. A line tick gives 21 beats, each read and then shown, with stalls.
// A set pixel or rectangle reads and then writes back each byte touched; a
// screen fill writes one stored byte per cycle (2400). After reset a clearing
// pass runs over all 2400 bytes of the pixel memory before the first item is taken.
// The result beat is held in place while rsp_tready is low.
module mono_framebuffer_draw_and_scanout (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: x_first[7:0], y_first[15:8], x_second[23:16], y_second[31:24], value[39:32]
   input  logic [39:0] req_tdata,
   // tuser: action[2:0]
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: status[1:0], pixel_byte[9:2], line_color[12:10], image_line[13], zero[15:14]
   output logic [15:0] rsp_tdata,
   output logic        rsp_tlast
);
   import mfb_pkg::*;

   cmd_type    cmd;
   sts_type    sts;
   logic [1:0] status;
   logic [7:0] pixel_byte;
   logic [2:0] line_color;
   logic       image_line;

   // Sequencer.
   mfb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_action (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   // Memories, counters and result fields.
   mfb_data u_data (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_action (req_tuser),
      .x_first    (req_tdata[7:0]),
      .y_first    (req_tdata[15:8]),
      .x_second   (req_tdata[23:16]),
      .y_second   (req_tdata[31:24]),
      .value      (req_tdata[39:32]),
      .status     (status),
      .pixel_byte (pixel_byte),
      .line_color (line_color),
      .image_line (image_line),
      .last       (rsp_tlast)
   );

   assign rsp_tdata = {2'b00, image_line, line_color, pixel_byte, status};

endmodule
